FILE: design/ksf_pkg.sv
// ----------------------------------------------------------------------------
// ksf_pkg
// Shared constants for the keyboard scancode FIFO: depth, widths, scancodes
// and operation codes.
// ----------------------------------------------------------------------------
package ksf_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int IDX_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_W     = (CNT_W > 8) ? CNT_W : 8;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_NUM_MAKE     = 8'h45;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

FILE: design/ksf_if.sv
// ----------------------------------------------------------------------------
// ksf_if
// Valid/ready channels of the keyboard scancode FIFO: request in, result out.
// ----------------------------------------------------------------------------
interface ksf_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] scan_byte;

    modport source (output valid, output operation, output scan_byte, input ready);
    modport sink   (input valid, input operation, input scan_byte, output ready);
endinterface

interface ksf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       led_refresh;
    logic [2:0] led_mask;
    logic       dropped;
    logic       uppercase;
    logic [7:0] fill_level;

    modport source (
        output valid, output read_byte, output read_valid, output led_refresh,
        output led_mask, output dropped, output uppercase, output fill_level,
        input ready
    );
    modport sink (
        input valid, input read_byte, input read_valid, input led_refresh,
        input led_mask, input dropped, input uppercase, input fill_level,
        output ready
    );
endinterface

FILE: design/keyboard_scancode_fifo_with_modifiers_core.sv
// An input passes through the input register, then the result register.
// One item per cycle unless the output stalls; state and FIFO update in one pass.
// The FIFO store is a single-port-write, single-read memory with registered read.
// Reset (sync, active low) clears modifiers, indexes, count and stage valids.
// FIFO contents are not cleared; entries are only read after being written.
// ----------------------------------------------------------------------------
// keyboard_scancode_fifo_with_modifiers_core
// PS/2 set-1 scancode ring FIFO with shift, caps lock and num lock tracking.
// ----------------------------------------------------------------------------
module keyboard_scancode_fifo_with_modifiers_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ksf_in_if.sink        i_in,
    ksf_out_if.source     o_out
);
    import ksf_pkg::*;

    logic       r_s1_v;
    logic       r_s1_op;
    logic [7:0] r_s1_byte;

    logic r_shift, r_caps, r_num;
    logic n_shift, n_caps, n_num;
    t_idx r_wr, r_rd, n_wr, n_rd;
    t_cnt r_cnt, n_cnt;

    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_mem_q;

    logic       r_o_v;
    logic       r_o_rd_valid;
    logic       r_o_refresh;
    logic [2:0] r_o_mask;
    logic       r_o_drop;
    logic       r_o_upper;
    logic [7:0] r_o_fill;

    logic              s2_ready, s1_fire, is_scan, full, empty, push, pop, refresh;
    logic [FILL_W-1:0] cnt_ext;

    assign s2_ready   = !r_o_v || o_out.ready;
    assign s1_fire    = r_s1_v && s2_ready;
    assign i_in.ready = !r_s1_v || s2_ready;

    assign is_scan = (r_s1_op == OP_SCAN);
    assign full    = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign empty   = (r_cnt == '0);
    assign push    = is_scan && !full;
    assign pop     = !is_scan && !empty;

    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        n_num   = r_num;
        refresh = 1'b0;
        if (is_scan) begin
            unique case (r_s1_byte)
                SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: begin
                    n_shift = 1'b1;
                end
                SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: begin
                    n_shift = 1'b0;
                end
                SC_CAPS_MAKE: begin
                    n_caps  = !r_caps;
                    refresh = 1'b1;
                end
                SC_NUM_MAKE: begin
                    n_num   = !r_num;
                    refresh = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr  = (r_wr == IDX_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            n_cnt = r_cnt + 1'b1;
        end else if (pop) begin
            n_rd  = (r_rd == IDX_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            n_cnt = r_cnt - 1'b1;
        end
    end

    assign cnt_ext = FILL_W'(n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_v <= 1'b1;
        end else if (s1_fire) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_op   <= i_in.operation;
            r_s1_byte <= i_in.scan_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_num   <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else if (s1_fire) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_num   <= n_num;
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && push) begin
            r_mem[r_wr] <= r_s1_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && pop) begin
            r_mem_q <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_fire) begin
            r_o_v <= 1'b1;
        end else if (o_out.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_o_rd_valid <= pop;
            r_o_refresh  <= refresh;
            r_o_mask     <= refresh ? {n_caps, n_num, 1'b0} : 3'b000;
            r_o_drop     <= is_scan && full;
            r_o_upper    <= n_shift || n_caps;
            r_o_fill     <= cnt_ext[7:0];
        end
    end

    assign o_out.valid       = r_o_v;
    assign o_out.read_byte   = r_o_rd_valid ? r_mem_q : 8'h00;
    assign o_out.read_valid  = r_o_rd_valid;
    assign o_out.led_refresh = r_o_refresh;
    assign o_out.led_mask    = r_o_mask;
    assign o_out.dropped     = r_o_drop;
    assign o_out.uppercase   = r_o_upper;
    assign o_out.fill_level  = r_o_fill;

endmodule

FILE: design/ksf_chk.sv
// ----------------------------------------------------------------------------
// ksf_chk
// Port-level checks for the keyboard scancode FIFO result stream.
// ----------------------------------------------------------------------------
module ksf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_byte,
    input logic       i_read_valid,
    input logic       i_dropped,
    input logic [7:0] i_fill_level
);
    logic       r_last_fill;
    logic [7:0] r_fill;
    logic       xfer;

    assign xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 8'h00;
            r_last_fill <= 1'b0;
        end else if (xfer) begin
            r_fill      <= i_fill_level;
            r_last_fill <= 1'b1;
        end
    end

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_read_valid |-> i_fill_level == 8'(r_fill - 8'd1))
        else $error("pop did not lower fill level by one");

    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_dropped |-> i_fill_level == r_fill && (r_fill != 8'h00 || r_last_fill))
        else $error("dropped transfer changed fill level");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !i_read_valid |-> i_read_byte == 8'h00)
        else $error("read byte nonzero without a pop");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fill_level)
            && $stable(i_read_byte))
        else $error("stalled result changed");

endmodule

bind keyboard_scancode_fifo_with_modifiers_core ksf_chk u_ksf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_read_byte  (o_out.read_byte),
    .i_read_valid (o_out.read_valid),
    .i_dropped    (o_out.dropped),
    .i_fill_level (o_out.fill_level)
);

FILE: test/tb_keyboard_scancode_fifo_with_modifiers_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyboard_scancode_fifo_with_modifiers_core
// Checks the scancode FIFO against a behavioral predictor that tracks shift,
// caps lock, num lock and the buffered bytes. A directed list covers the
// modifier and lock codes, field extremes and reads on an empty FIFO. It is
// followed by an overflow-and-drain run and by random segments of varying
// scan/read mix. Both handshakes are throttled at random outside a steady window.
// ----------------------------------------------------------------------------
module tb_keyboard_scancode_fifo_with_modifiers_core;
    import ksf_pkg::*;

    localparam logic [7:0] SC_CAPS_BREAK = SC_CAPS_MAKE | 8'h80;
    localparam logic [7:0] SC_NUM_BREAK  = SC_NUM_MAKE | 8'h80;
    localparam int         N_ITEMS       = 1350;

    typedef struct packed {
        logic       op;
        logic [7:0] code;
        logic       settle;
    } t_key_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       led_refresh;
        logic [2:0] led_mask;
        logic       dropped;
        logic       uppercase;
        logic [7:0] fill_level;
    } t_key_res;

    logic i_clk;
    logic i_rst_n;

    ksf_in_if  u_in_if ();
    ksf_out_if u_out_if ();

    keyboard_scancode_fifo_with_modifiers_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    t_key_req   key_requests[$];
    t_key_res   expected_results[$];
    logic [7:0] kbd_fifo[$];
    logic       shift_held;
    logic       caps_on;
    logic       num_on;
    t_key_req   cur_req;
    t_key_res   exp_res;
    bit         req_pending;
    int         accepted;
    int         errors;
    logic       steady;

    assign steady = (accepted >= 500) && (accepted < 800);

    always #1 i_clk = ~i_clk;

    function automatic t_key_res kbd_predict(t_key_req req);
        t_key_res r;
        r = '0;
        if (req.op == OP_SCAN) begin
            case (req.code)
                SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_held = 1'b1;
                SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_held = 1'b0;
                SC_CAPS_MAKE: begin
                    caps_on       = !caps_on;
                    r.led_refresh = 1'b1;
                end
                SC_NUM_MAKE: begin
                    num_on        = !num_on;
                    r.led_refresh = 1'b1;
                end
                default: ;
            endcase
            if (r.led_refresh)
                r.led_mask = {caps_on, num_on, 1'b0};
            if (kbd_fifo.size() < FIFO_DEPTH)
                kbd_fifo.push_back(req.code);
            else
                r.dropped = 1'b1;
        end else if (kbd_fifo.size() != 0) begin
            r.read_byte  = kbd_fifo.pop_front();
            r.read_valid = 1'b1;
        end
        r.uppercase  = shift_held | caps_on;
        r.fill_level = 8'(kbd_fifo.size());
        return r;
    endfunction

    function automatic logic [7:0] pick_scancode();
        logic [7:0] codes[8];
        codes = '{SC_LSHIFT_MAKE, SC_RSHIFT_MAKE, SC_LSHIFT_BREAK, SC_RSHIFT_BREAK,
                  SC_CAPS_MAKE, SC_NUM_MAKE, SC_CAPS_BREAK, SC_NUM_BREAK};
        if ($urandom_range(0, 99) < 35)
            return codes[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_key(logic op, logic [7:0] code, logic settle = 1'b0);
        t_key_req req;
        req.op     = op;
        req.code   = code;
        req.settle = settle;
        key_requests.push_back(req);
    endtask

    task automatic check_field(string fname, logic [7:0] e, logic [7:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, e, a);
            errors++;
        end
    endtask

    // driver: inputs and ready change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            u_in_if.valid  <= 1'b0;
            u_out_if.ready <= 1'b0;
        end else begin
            u_out_if.ready <= steady || ($urandom_range(0, 99) >= 31);
            if (!req_pending) begin
                if (key_requests.size() != 0
                    && (!key_requests[0].settle || expected_results.size() == 0)
                    && (steady || $urandom_range(0, 99) >= 31)) begin
                    cur_req             = key_requests.pop_front();
                    req_pending         = 1'b1;
                    u_in_if.valid      <= 1'b1;
                    u_in_if.operation  <= cur_req.op;
                    u_in_if.scan_byte  <= cur_req.code;
                end else begin
                    u_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: transfers sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (u_out_if.valid && u_out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got byte %0h fill %0h",
                             $time, u_out_if.read_byte, u_out_if.fill_level);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("read_byte", exp_res.read_byte, u_out_if.read_byte);
                    check_field("read_valid", 8'(exp_res.read_valid), 8'(u_out_if.read_valid));
                    check_field("led_refresh", 8'(exp_res.led_refresh),
                                8'(u_out_if.led_refresh));
                    check_field("led_mask", 8'(exp_res.led_mask), 8'(u_out_if.led_mask));
                    check_field("dropped", 8'(exp_res.dropped), 8'(u_out_if.dropped));
                    check_field("uppercase", 8'(exp_res.uppercase), 8'(u_out_if.uppercase));
                    check_field("fill_level", exp_res.fill_level, u_out_if.fill_level);
                end
            end
            if (u_in_if.valid && u_in_if.ready && req_pending) begin
                expected_results.push_back(kbd_predict(cur_req));
                req_pending = 1'b0;
                accepted++;
            end
        end
    end

    initial begin
        int seg_len;
        int scan_pct;
        int pcts[5];

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        u_in_if.valid      = 1'b0;
        u_in_if.operation  = OP_SCAN;
        u_in_if.scan_byte  = 8'h00;
        u_out_if.ready     = 1'b0;
        shift_held         = 1'b0;
        caps_on            = 1'b0;
        num_on             = 1'b0;
        req_pending        = 1'b0;
        accepted           = 0;
        errors             = 0;
        pcts               = '{0, 10, 50, 90, 100};

        // directed: empty read, extremes, every modifier and lock code
        queue_key(OP_READ, 8'hFF);
        queue_key(OP_SCAN, 8'h00);
        queue_key(OP_SCAN, 8'hFF);
        queue_key(OP_SCAN, SC_LSHIFT_MAKE);
        queue_key(OP_READ, 8'h00);
        queue_key(OP_SCAN, SC_LSHIFT_BREAK);
        queue_key(OP_SCAN, SC_RSHIFT_MAKE);
        queue_key(OP_SCAN, SC_RSHIFT_BREAK);
        queue_key(OP_SCAN, SC_CAPS_MAKE);
        queue_key(OP_SCAN, SC_CAPS_BREAK);
        queue_key(OP_SCAN, SC_NUM_MAKE);
        queue_key(OP_SCAN, SC_NUM_BREAK);
        queue_key(OP_SCAN, SC_CAPS_MAKE);
        queue_key(OP_SCAN, SC_NUM_MAKE);
        queue_key(OP_SCAN, 8'h80);
        queue_key(OP_SCAN, 8'h7F);
        repeat (12) queue_key(OP_READ, 8'h55);

        // overflow the FIFO, then drain it past empty
        repeat (FIFO_DEPTH + 12) queue_key(OP_SCAN, pick_scancode());
        queue_key(OP_READ, 8'h00, 1'b1);
        repeat (FIFO_DEPTH + 16) queue_key(OP_READ, 8'($urandom_range(0, 255)));

        // random segments with varying scan/read mix
        while (key_requests.size() < N_ITEMS) begin
            seg_len  = $urandom_range(10, 80);
            scan_pct = pcts[$urandom_range(0, 4)];
            for (int i = 0; i < seg_len; i++)
                queue_key(($urandom_range(0, 99) < scan_pct) ? OP_SCAN : OP_READ,
                          pick_scancode(), (i == 0) && ($urandom_range(0, 3) == 0));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (key_requests.size() != 0 || req_pending || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0)
            $display("tb_keyboard_scancode_fifo_with_modifiers_core passed");
        else
            $display("tb_keyboard_scancode_fifo_with_modifiers_core failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_keyboard_scancode_fifo_with_modifiers_core failed");
        $finish;
    end

endmodule

FILE: sim.f
design/ksf_pkg.sv
design/ksf_if.sv
design/keyboard_scancode_fifo_with_modifiers_core.sv
design/ksf_chk.sv
test/tb_keyboard_scancode_fifo_with_modifiers_core.sv
